// ----- rtl/alt_pkg.sv -----
// Shared types and constants of the adjacency list table.
`timescale 1ns / 1ps

package alt_pkg;

    // Fixed widths of the channel fields.
    localparam int MODE_W   = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int ROWCNT_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIRST  = 2'd2,
        MODE_LIST   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Control of the shared match unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } t_match_ctl;

endpackage

// ----- rtl/alt_in_if.sv -----
// Request channel of the adjacency list table.
`timescale 1ns / 1ps

interface alt_in_if;
    import alt_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   neighbor;

    modport source (output valid, mode, node, neighbor, input ready);
    modport sink   (input valid, mode, node, neighbor, output ready);
endinterface

// ----- rtl/alt_out_if.sv -----
// Result channel of the adjacency list table.
`timescale 1ns / 1ps

interface alt_out_if;
    import alt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     neighbor_out;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic [ROWCNT_W-1:0] row_count;

    modport source (output valid, neighbor_out, status, last, row_count, input ready);
    modport sink   (input valid, neighbor_out, status, last, row_count, output ready);
endinterface

// ----- rtl/adjacency_list_table_core.sv -----
// Top level of the adjacency list table: sequencer, row memories and result register.
`timescale 1ns / 1ps

// Channel   Modport  Fields                                  Transaction
// i_in      sink     mode, node, neighbor                    one operation
// o_out     source   neighbor_out, status, last, row_count   one result
//
// An operation first scans the row keys one per cycle through the shared compare
// unit. For a known node the row degree is read next; add then writes the
// neighbor and the new degree, remove scans the row and shifts each later neighbor
// down with a read step and a write step, and a list reads and emits the neighbors
// in turn (first only the one). Reset clears only the row count, the output valid
// flag and the control state; the memories are read only below the count and the
// row degree. The block takes a new transaction only when idle; a finished result
// waits in the output register, and a stalled output holds the list emission.

module adjacency_list_table_core #(
    parameter int MAX_NODES  = 16,
    parameter int MAX_DEGREE = 16,
    parameter int ID_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alt_in_if.sink    i_in,
    alt_out_if.source o_out
);
    import alt_pkg::*;

    // Stored id width: ids are kept in their low SW bits, the lesser of ID_BITS and ID_W.
    localparam int SW      = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int ROW_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DEG_AW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int RCW     = $clog2(MAX_NODES + 1);
    localparam int DCW     = $clog2(MAX_DEGREE + 1);
    localparam int CW      = (RCW > DCW) ? RCW : DCW;
    localparam int SAW     = ROW_AW + DEG_AW;
    localparam logic [RCW-1:0] NODES_C = RCW'(MAX_NODES);
    localparam logic [DCW-1:0] DEG_C   = DCW'(MAX_DEGREE);

    typedef enum logic [3:0] {
        S_IDLE,
        S_KSCAN,
        S_DEGRD,
        S_DEGWT,
        S_NSCAN,
        S_SHRD,
        S_SHWR,
        S_EMRD,
        S_EMIT,
        S_RESP
    } t_state;

    // Sequencer registers.
    t_state           r_state, n_state;
    t_mode            r_mode, n_mode;
    logic [SW-1:0]    r_node, n_node;
    logic [SW-1:0]    r_nb, n_nb;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_pv, n_pv;
    logic [CW-1:0]    r_ptag, n_ptag;
    logic [ROW_AW-1:0] r_row, n_row;
    logic [DCW-1:0]   r_deg, n_deg;
    logic [RCW-1:0]   r_rows_used, n_rows_used;
    t_status          r_st, n_st;

    // Result register.
    logic                r_out_vld, n_out_vld;
    logic [ID_W-1:0]     r_out_nb, n_out_nb;
    t_status             r_out_st, n_out_st;
    logic                r_out_last, n_out_last;
    logic [ROWCNT_W-1:0] r_out_rc, n_out_rc;

    // Memory ports.
    logic              w_key_we;
    logic [ROW_AW-1:0] w_key_wa;
    logic [SW-1:0]     w_key_rd;
    logic              w_deg_we;
    logic [ROW_AW-1:0] w_deg_wa;
    logic [DCW-1:0]    w_deg_wd;
    logic [DCW-1:0]    w_deg_rd;
    logic              w_st_we;
    logic [SAW-1:0]    w_st_wa;
    logic [SW-1:0]     w_st_wd;
    logic [SAW-1:0]    w_st_ra;
    logic [SW-1:0]     w_st_rd;

    // Shared compare unit.
    t_match_ctl        w_m_ctl;
    logic [SW-1:0]     w_m_data;
    logic [SW-1:0]     w_m_key;
    logic              w_m_found;
    logic [CW-1:0]     w_m_idx;

    logic              w_out_free;
    logic [CW:0]       w_cnt_inc;
    logic [31:0]       w_rc32;
    logic [31:0]       w_nrc32;

    alt_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_wa),
        .i_wdata (r_node),
        .i_raddr (r_cnt[ROW_AW-1:0]),
        .o_rdata (w_key_rd)
    );

    alt_ram #(.WIDTH(DCW), .DEPTH(MAX_NODES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (w_deg_we),
        .i_waddr (w_deg_wa),
        .i_wdata (w_deg_wd),
        .i_raddr (r_row),
        .o_rdata (w_deg_rd)
    );

    // Neighbor k of row r lives at {r, k}.
    alt_ram #(.WIDTH(SW), .DEPTH(2 ** SAW)) u_nb_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_wa),
        .i_wdata (w_st_wd),
        .i_raddr (w_st_ra),
        .o_rdata (w_st_rd)
    );

    alt_match #(.DATA_W(SW), .IDX_W(CW)) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_m_ctl),
        .i_data  (w_m_data),
        .i_key   (w_m_key),
        .i_idx   (r_ptag),
        .o_found (w_m_found),
        .o_idx   (w_m_idx)
    );

    // The compare unit looks at row keys during the key scan and at the row's
    // neighbors during the remove scan.
    assign w_m_data = (r_state == S_NSCAN) ? w_st_rd : w_key_rd;
    assign w_m_key  = (r_state == S_NSCAN) ? r_nb : r_node;

    // The shift step reads one entry ahead of the one it writes.
    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_st_ra   = (r_state == S_SHRD) ? {r_row, w_cnt_inc[DEG_AW-1:0]}
                                           : {r_row, r_cnt[DEG_AW-1:0]};

    assign w_out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign w_rc32  = 32'(r_rows_used);
    assign w_nrc32 = 32'(n_rows_used);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_node      = r_node;
        n_nb        = r_nb;
        n_cnt       = r_cnt;
        n_pv        = 1'b0;
        n_ptag      = r_ptag;
        n_row       = r_row;
        n_deg       = r_deg;
        n_rows_used = r_rows_used;
        n_st        = r_st;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_nb    = r_out_nb;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        n_out_rc    = r_out_rc;
        w_key_we    = 1'b0;
        w_key_wa    = r_rows_used[ROW_AW-1:0];
        w_deg_we    = 1'b0;
        w_deg_wa    = r_row;
        w_deg_wd    = r_deg;
        w_st_we     = 1'b0;
        w_st_wa     = {r_row, r_cnt[DEG_AW-1:0]};
        w_st_wd     = r_nb;
        w_m_ctl.clear = 1'b0;
        w_m_ctl.valid = r_pv;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode        = t_mode'(i_in.mode);
                    n_node        = i_in.node[SW-1:0];
                    n_nb          = i_in.neighbor[SW-1:0];
                    n_cnt         = '0;
                    w_m_ctl.clear = 1'b1;
                    n_state       = S_KSCAN;
                end
            end

            S_KSCAN: begin
                if (r_cnt != CW'(r_rows_used)) begin
                    n_pv   = 1'b1;
                    n_ptag = r_cnt;
                    n_cnt  = w_cnt_inc[CW-1:0];
                end else if (!r_pv) begin
                    if (w_m_found) begin
                        n_row   = w_m_idx[ROW_AW-1:0];
                        n_state = S_DEGRD;
                    end else if (r_mode == MODE_ADD) begin
                        if (r_rows_used >= NODES_C) begin
                            n_st = ST_FULL;
                        end else begin
                            // Open a new row holding just this neighbor.
                            w_key_we    = 1'b1;
                            w_deg_we    = 1'b1;
                            w_deg_wa    = r_rows_used[ROW_AW-1:0];
                            w_deg_wd    = DCW'(1);
                            w_st_we     = 1'b1;
                            w_st_wa     = {r_rows_used[ROW_AW-1:0], {DEG_AW{1'b0}}};
                            n_rows_used = r_rows_used + 1'b1;
                            n_st        = ST_OK;
                        end
                        n_state = S_RESP;
                    end else begin
                        n_st    = ST_NOT_FOUND;
                        n_state = S_RESP;
                    end
                end
            end

            S_DEGRD: begin
                n_state = S_DEGWT;
            end

            S_DEGWT: begin
                n_deg = w_deg_rd;
                n_cnt = '0;
                case (r_mode)
                    MODE_ADD: begin
                        if (w_deg_rd >= DEG_C) begin
                            n_st = ST_FULL;
                        end else begin
                            w_st_we  = 1'b1;
                            w_st_wa  = {r_row, w_deg_rd[DEG_AW-1:0]};
                            w_deg_we = 1'b1;
                            w_deg_wd = w_deg_rd + 1'b1;
                            n_st     = ST_OK;
                        end
                        n_state = S_RESP;
                    end
                    MODE_REMOVE: begin
                        w_m_ctl.clear = 1'b1;
                        n_state       = S_NSCAN;
                    end
                    default: begin
                        if (w_deg_rd == '0) begin
                            n_st    = ST_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_EMRD;
                        end
                    end
                endcase
            end

            S_NSCAN: begin
                if (r_cnt != CW'(r_deg)) begin
                    n_pv   = 1'b1;
                    n_ptag = r_cnt;
                    n_cnt  = w_cnt_inc[CW-1:0];
                end else if (!r_pv) begin
                    if (w_m_found) begin
                        n_cnt   = w_m_idx;
                        n_state = S_SHRD;
                    end else begin
                        n_st    = ST_NOT_FOUND;
                        n_state = S_RESP;
                    end
                end
            end

            S_SHRD: begin
                if (w_cnt_inc < (CW + 1)'(r_deg)) begin
                    n_state = S_SHWR;
                end else begin
                    w_deg_we = 1'b1;
                    w_deg_wd = r_deg - 1'b1;
                    n_st     = ST_OK;
                    n_state  = S_RESP;
                end
            end

            S_SHWR: begin
                // Close the gap: entry k takes the value of entry k + 1.
                w_st_we = 1'b1;
                w_st_wd = w_st_rd;
                n_cnt   = w_cnt_inc[CW-1:0];
                n_state = S_SHRD;
            end

            S_EMRD: begin
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_nb   = ID_W'(w_st_rd);
                    n_out_st   = ST_OK;
                    n_out_last = (r_mode == MODE_FIRST) || (w_cnt_inc == (CW + 1)'(r_deg));
                    n_out_rc   = w_rc32[ROWCNT_W-1:0];
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = w_cnt_inc[CW-1:0];
                        n_state = S_EMRD;
                    end
                end
            end

            S_RESP: begin
                if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_nb   = '0;
                    n_out_st   = r_st;
                    n_out_last = 1'b1;
                    n_out_rc   = w_nrc32[ROWCNT_W-1:0];
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pv        <= 1'b0;
            r_rows_used <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_rows_used <= n_rows_used;
            r_out_vld   <= n_out_vld;
        end
        r_mode     <= n_mode;
        r_node     <= n_node;
        r_nb       <= n_nb;
        r_cnt      <= n_cnt;
        r_ptag     <= n_ptag;
        r_row      <= n_row;
        r_deg      <= n_deg;
        r_st       <= n_st;
        r_out_nb   <= n_out_nb;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
        r_out_rc   <= n_out_rc;
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.neighbor_out = r_out_nb;
    assign o_out.status       = r_out_st;
    assign o_out.last         = r_out_last;
    assign o_out.row_count    = r_out_rc;

    // The table never holds more rows than it has room for.
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_used <= NODES_C)
        else $error("row count exceeds the table size");

    // Rows are only ever opened one at a time and never closed.
    a_rows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rows_used != $past(r_rows_used)) |-> (r_rows_used == $past(r_rows_used) + 1'b1))
        else $error("row count changed by other than one");

    // A written degree never exceeds the row capacity.
    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deg_we |-> (w_deg_wd <= DEG_C))
        else $error("row degree written beyond capacity");

    // A hit of the remove scan lies inside the row.
    a_hit_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_NSCAN) && !r_pv && (r_cnt == CW'(r_deg)) && w_m_found)
        |-> (w_m_idx < CW'(r_deg)))
        else $error("remove scan hit outside the row");

    // Only a successful query carries a neighbor id.
    a_nb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_st != ST_OK)) |-> (r_out_nb == '0))
        else $error("non-ok result carries a neighbor id");
endmodule

// ----- rtl/alt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module alt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/alt_match.sv -----
// Shared equality compare unit that remembers the last matching index of a scan.
`timescale 1ns / 1ps

module alt_match #(
    parameter int DATA_W = 16,
    parameter int IDX_W  = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  alt_pkg::t_match_ctl i_ctl,
    input  logic [DATA_W-1:0]   i_data,
    input  logic [DATA_W-1:0]   i_key,
    input  logic [IDX_W-1:0]    i_idx,
    output logic                o_found,
    output logic [IDX_W-1:0]    o_idx
);
    import alt_pkg::*;

    logic             r_found;
    logic [IDX_W-1:0] r_idx;

    // A later hit overrides an earlier one, so the last occurrence wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.valid && (i_data == i_key)) begin
            r_found <= 1'b1;
        end
        if (i_ctl.valid && (i_data == i_key)) begin
            r_idx <= i_idx;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the adjacency list table core.
`timescale 1ns / 1ps

module tb_top;
    import alt_pkg::*;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_DEG     = 16;
    localparam int NO_ROW      = -1;
    localparam int KEY_POOL    = 20;
    localparam int NBR_POOL    = 6;
    localparam int TOTAL_ITEMS = 380;
    localparam int QUIET_LIMIT = 3000;
    localparam int SHOWN_ERRS  = 10;

    logic i_clk;
    logic i_rst_n;

    alt_in_if  in_ch ();
    alt_out_if out_ch ();

    adjacency_list_table_core #(
        .MAX_NODES  (MAX_ROWS),
        .MAX_DEGREE (MAX_DEG),
        .ID_BITS    (ID_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // One result transaction as the table is expected to produce it.
    typedef struct packed {
        logic [ID_W-1:0]     neighbor;
        t_status             status;
        logic                last;
        logic [ROWCNT_W-1:0] row_count;
    } t_nbr_result;

    // Keeps a private copy of the adjacency table, predicts the results of
    // every accepted request and compares them with what the block returns.
    class adjacency_checker;
        bit [ROWCNT_W-1:0] rows_used;
        bit [ID_W-1:0]     row_key [MAX_ROWS];
        bit [4:0]          row_degree [MAX_ROWS];
        bit [ID_W-1:0]     row_nbrs [MAX_ROWS][MAX_DEG];
        t_nbr_result       pending_results [$];
        int unsigned       errors;

        function int pending();
            return pending_results.size();
        endfunction

        function void push_result(bit [ID_W-1:0] nb, t_status st, bit last);
            t_nbr_result r;
            r.neighbor  = nb;
            r.status    = st;
            r.last      = last;
            r.row_count = rows_used;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void apply_request(t_mode op, bit [ID_W-1:0] node, bit [ID_W-1:0] nb);
            int hit;
            int deg;
            int pos;
            hit = NO_ROW;
            for (int r = 0; r < rows_used; r++) begin
                if (row_key[r] == node) hit = r;
            end

            if (op == MODE_ADD) begin
                if (hit == NO_ROW) begin
                    if (rows_used >= MAX_ROWS) begin
                        push_result('0, ST_FULL, 1'b1);
                        return;
                    end
                    hit = rows_used;
                    row_key[hit]    = node;
                    row_degree[hit] = '0;
                    rows_used++;
                end
                if (row_degree[hit] >= MAX_DEG) begin
                    push_result('0, ST_FULL, 1'b1);
                    return;
                end
                row_nbrs[hit][row_degree[hit]] = nb;
                row_degree[hit]++;
                push_result('0, ST_OK, 1'b1);
                return;
            end

            if (hit == NO_ROW) begin
                push_result('0, ST_NOT_FOUND, 1'b1);
                return;
            end
            deg = row_degree[hit];

            if (op == MODE_REMOVE) begin
                // The last occurrence goes; the tail moves down by one.
                pos = NO_ROW;
                for (int k = 0; k < deg; k++) begin
                    if (row_nbrs[hit][k] == nb) pos = k;
                end
                if (pos == NO_ROW) begin
                    push_result('0, ST_NOT_FOUND, 1'b1);
                    return;
                end
                for (int k = pos; k + 1 < deg; k++) begin
                    row_nbrs[hit][k] = row_nbrs[hit][k+1];
                end
                row_degree[hit] = deg - 1;
                push_result('0, ST_OK, 1'b1);
                return;
            end

            if (deg == 0) begin
                push_result('0, ST_EMPTY, 1'b1);
            end else if (op == MODE_FIRST) begin
                push_result(row_nbrs[hit][0], ST_OK, 1'b1);
            end else begin
                for (int k = 0; k < deg; k++) begin
                    push_result(row_nbrs[hit][k], ST_OK, k == deg - 1);
                end
            end
        endfunction

        function void check_result(logic [ID_W-1:0] nb, logic [STATUS_W-1:0] st,
                                   logic last, logic [ROWCNT_W-1:0] rc);
            t_nbr_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRS) begin
                    $display("%0t: unexpected result nb=%h st=%0d last=%b rows=%0d",
                             $realtime, nb, st, last, rc);
                end
                return;
            end
            want = pending_results.pop_front();
            if (want.neighbor !== nb || want.status !== st || want.last !== last ||
                want.row_count !== rc) begin
                errors++;
                if (errors <= SHOWN_ERRS) begin
                    $display("%0t: result mismatch exp nb=%h st=%0d last=%b rows=%0d",
                             $realtime, want.neighbor, want.status, want.last,
                             want.row_count);
                    $display("%0t:                 got nb=%h st=%0d last=%b rows=%0d",
                             $realtime, nb, st, last, rc);
                end
            end
        endfunction
    endclass

    adjacency_checker board;

    // Stimulus state shared by the sender tasks.
    bit [ID_W-1:0] key_pool [KEY_POOL];
    bit [ID_W-1:0] nbr_pool [NBR_POOL];
    int unsigned   sent_count;
    int unsigned   burst_left;
    bit            hold_off_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one request and waits until the block takes it. The sender
    // works in bursts; between bursts valid drops for a random gap.
    task automatic send_op(t_mode op, bit [ID_W-1:0] node, bit [ID_W-1:0] nb);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
            // Now and then a long burst gives a stretch with no idling.
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= op;
        in_ch.node     <= node;
        in_ch.neighbor <= nb;
        do @(posedge i_clk); while (!in_ch.ready);
        board.apply_request(op, node, nb);
        sent_count++;
        if (sent_count == 100) hold_off_request = 1'b1;
    endtask

    // Sender pause: nothing is offered until every expected result is back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_item(int unsigned pool_size);
        t_mode         op;
        bit [ID_W-1:0] node;
        bit [ID_W-1:0] nb;
        int unsigned   pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = MODE_ADD;
        else if (pick < 65) op = MODE_REMOVE;
        else if (pick < 80) op = MODE_FIRST;
        else                op = MODE_LIST;
        // A few requests address arbitrary nodes, mostly unknown ones.
        if ($urandom_range(0, 19) == 0) node = ID_W'($urandom());
        else                            node = key_pool[$urandom_range(0, pool_size - 1)];
        if ($urandom_range(0, 3) == 0) nb = ID_W'($urandom());
        else                           nb = nbr_pool[$urandom_range(0, NBR_POOL - 1)];
        send_op(op, node, nb);
    endtask

    // Pushes one row past its capacity, lists it, removes some of the neighbors
    // that went in, then asks for the first neighbor.
    task automatic fill_row_burst();
        bit [ID_W-1:0] node;
        bit [ID_W-1:0] nb;
        bit [ID_W-1:0] added [$];
        int unsigned   n;
        node = key_pool[$urandom_range(0, 5)];
        n = $urandom_range(MAX_DEG + 1, MAX_DEG + 4);
        repeat (n) begin
            nb = ($urandom_range(0, 1) == 0) ? ID_W'($urandom())
                                             : nbr_pool[$urandom_range(0, NBR_POOL - 1)];
            added.insert(added.size(), nb);
            send_op(MODE_ADD, node, nb);
        end
        send_op(MODE_LIST, node, ID_W'($urandom()));
        repeat ($urandom_range(2, 6)) begin
            send_op(MODE_REMOVE, node, added[$urandom_range(0, added.size() - 1)]);
        end
        send_op(MODE_FIRST, node, ID_W'($urandom()));
    endtask

    // Opens rows for fresh nodes until the table is certainly full.
    task automatic fill_table();
        repeat (MAX_ROWS + 2) send_op(MODE_ADD, ID_W'($urandom()), ID_W'($urandom()));
    endtask

    // Stimulus and end of run.
    initial begin : stimulus
        bit drain_done;
        bit table_filled;
        board            = new();
        drain_done       = 1'b0;
        table_filled     = 1'b0;
        sent_count       = 0;
        burst_left       = 0;
        hold_off_request = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_ADD;
        in_ch.node       = '0;
        in_ch.neighbor   = '0;
        foreach (key_pool[i]) key_pool[i] = ID_W'($urandom());
        foreach (nbr_pool[i]) nbr_pool[i] = ID_W'($urandom());
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Queries on an empty table, then the edges of the id range,
        // duplicates, removal of the last copy and rows that run empty.
        send_op(MODE_FIRST,  16'h1234, 16'h0000);
        send_op(MODE_LIST,   16'h1234, 16'hFFFF);
        send_op(MODE_REMOVE, 16'h1234, 16'h0001);
        send_op(MODE_ADD,    16'h0000, 16'h0000);
        send_op(MODE_ADD,    16'hFFFF, 16'hFFFF);
        send_op(MODE_ADD,    16'hFFFF, 16'h0000);
        send_op(MODE_ADD,    16'hFFFF, 16'hFFFF);
        send_op(MODE_ADD,    16'hFFFF, 16'h5A5A);
        send_op(MODE_LIST,   16'hFFFF, 16'h0000);
        send_op(MODE_FIRST,  16'hFFFF, 16'h0000);
        send_op(MODE_REMOVE, 16'hFFFF, 16'hFFFF);
        send_op(MODE_LIST,   16'hFFFF, 16'h0000);
        send_op(MODE_REMOVE, 16'hFFFF, 16'h1111);
        send_op(MODE_REMOVE, 16'h0000, 16'h0000);
        send_op(MODE_FIRST,  16'h0000, 16'h0000);
        send_op(MODE_LIST,   16'h0000, 16'h0000);
        send_op(MODE_REMOVE, 16'h0000, 16'h0000);
        send_op(MODE_REMOVE, 16'hFFFF, 16'h0000);
        send_op(MODE_FIRST,  16'hFFFF, 16'hA5A5);
        send_op(MODE_ADD,    16'h0000, 16'hA5A5);
        send_op(MODE_LIST,   16'h0000, 16'h5A5A);
        send_op(MODE_FIRST,  16'h8000, 16'h0000);
        wait_results_drained();

        // Random part: a small key pool first so rows grow deep, then the
        // full pool so that the table runs out of rows.
        fill_row_burst();
        while (sent_count < TOTAL_ITEMS) begin
            if (!drain_done && sent_count >= 200) begin
                drain_done = 1'b1;
                wait_results_drained();
            end
            if (!table_filled && sent_count >= 280) begin
                table_filled = 1'b1;
                fill_table();
            end else if ($urandom_range(0, 99) < 6) begin
                fill_row_burst();
            end else begin
                random_item(sent_count < 190 ? 6 : KEY_POOL);
            end
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: ready steps through four patterns (always high, random, mostly
    // high, sparse), and once it is held low long enough for the input to back up.
    initial begin : result_sink
        int unsigned cyc;
        int unsigned hold_left;
        bit          hold_done;
        cyc          = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_off_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = $urandom_range(250, 400);
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case ((cyc / 97) % 4)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: out_ch.ready <= ($urandom_range(0, 9) < 8);
                    default: out_ch.ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            board.check_result(out_ch.neighbor_out, out_ch.status, out_ch.last,
                               out_ch.row_count);
        end
    end

    // Ends the run when no transaction moves on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/alt_pkg.sv
rtl/alt_in_if.sv
rtl/alt_out_if.sv
rtl/alt_ram.sv
rtl/alt_match.sv
rtl/adjacency_list_table_core.sv
tb/tb_top.sv
